>>> hw/rtl/b64e_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the character table for the base64 line encoder
package b64e_pkg;

  localparam int unsigned LineBytes = 3000;
  localparam int unsigned CountW    = 12;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CountW-1:0] LineLimit = CountW'(LineBytes);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);

  localparam logic [6:0] PadChar = 7'd61;

  // one finished group as handed from front to back
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nreal;
    logic        eol;
  } grp_t;

  // queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  function automatic logic [6:0] b64_char(input logic [5:0] sextet);
    logic [6:0] c;
    if (sextet < 6'd26) begin
      c = 7'd65 + {1'b0, sextet};
    end else if (sextet < 6'd52) begin
      c = 7'd71 + {1'b0, sextet};
    end else if (sextet < 6'd62) begin
      c = {1'b0, sextet} - 7'd4;
    end else if (sextet == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/b64e_in_if.sv
`timescale 1ns / 1ps
// byte input channel
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

>>> hw/rtl/b64e_out_if.sv
`timescale 1ns / 1ps
// character output channel
interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       line_end;
  logic       run_last;

  modport source (output valid, output out_char, output line_end, output run_last,
                  input ready);
  modport sink (input valid, input out_char, input line_end, input run_last,
                output ready);
endinterface

>>> hw/rtl/b64e_front.sv
`timescale 1ns / 1ps
// front end: collects bytes into groups and tracks line length
module b64e_front
  import b64e_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  b64e_in_if.sink in_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output grp_t    grp_o
);

  logic [1:0]        phase_q, phase_d;
  logic [15:0]       held_q, held_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_inc;
  logic              accept;
  logic              done;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  assign count_inc = (count_q == CountMax) ? CountMax : count_q + 1'b1;

  // a group closes on its third byte or on the final byte
  assign done = (phase_q[1] || in_i.final_byte);

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    count_d     = count_q;
    push_o      = 1'b0;
    grp_o.word  = {held_q, in_i.data_byte};
    grp_o.nreal = 2'd3;
    grp_o.eol   = in_i.final_byte || (count_inc >= LineLimit);
    case (phase_q)
      2'd0: begin
        grp_o.word  = {in_i.data_byte, 16'h0000};
        grp_o.nreal = 2'd1;
      end
      2'd1: begin
        grp_o.word  = {held_q[15:8], in_i.data_byte, 8'h00};
        grp_o.nreal = 2'd2;
      end
      default: begin
      end
    endcase
    if (accept) begin
      if (phase_q == 2'd0) begin
        held_d[15:8] = in_i.data_byte;
      end else if (phase_q == 2'd1) begin
        held_d[7:0] = in_i.data_byte;
      end
      if (done) begin
        push_o  = 1'b1;
        phase_d = 2'd0;
        count_d = grp_o.eol ? '0 : count_inc;
      end else begin
        phase_d = phase_q + 2'd1;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

>>> hw/rtl/b64e_fifo.sv
`timescale 1ns / 1ps
// short group queue between front and back
module b64e_fifo
  import b64e_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  grp_t    grp_i,
  input  logic    pop_i,
  output grp_t    head_o,
  output q_stat_t stat_o
);

  grp_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.full      = (fill_q == FillW'(QueueDepth));
  assign stat_o.not_empty = (fill_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= grp_i;
    end
  end

endmodule

>>> hw/rtl/b64e_back.sv
`timescale 1ns / 1ps
// back end: turns one group into four characters, one per cycle while the output is not stalled
module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_stat_t     q_stat_i,
  input  grp_t        head_i,
  output logic        pop_o,
  b64e_out_if.source  out_o
);

  grp_t       grp_q, grp_d;
  logic [1:0] idx_q, idx_d;
  logic       active_q, active_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q, char_d;
  logic       eol_q, eol_d;
  logic       last_q, last_d;
  logic       adv;
  grp_t       src;
  logic [1:0] k;
  logic [5:0] sextet;
  logic       pad;

  assign out_o.valid    = valid_q;
  assign out_o.out_char = char_q;
  assign out_o.line_end = eol_q;
  assign out_o.run_last = last_q;

  assign adv   = !valid_q || out_o.ready;
  assign pop_o = adv && !active_q && q_stat_i.not_empty;

  // a new group starts straight from the queue head, no bubble between groups
  assign src = active_q ? grp_q : head_i;
  assign k   = active_q ? idx_q : 2'd0;

  always_comb begin
    case (k)
      2'd0:    sextet = src.word[23:18];
      2'd1:    sextet = src.word[17:12];
      2'd2:    sextet = src.word[11:6];
      default: sextet = src.word[5:0];
    endcase
    pad = ((k == 2'd2) && (src.nreal < 2'd2)) || ((k == 2'd3) && (src.nreal < 2'd3));
  end

  always_comb begin
    grp_d    = grp_q;
    idx_d    = idx_q;
    active_d = active_q;
    valid_d  = valid_q;
    char_d   = char_q;
    eol_d    = eol_q;
    last_d   = last_q;
    if (adv) begin
      valid_d = active_q || q_stat_i.not_empty;
      char_d  = pad ? PadChar : b64_char(sextet);
      eol_d   = (k == 2'd3) && src.eol;
      last_d  = (k == 2'd3);
      if (pop_o) begin
        grp_d    = head_i;
        idx_d    = 2'd1;
        active_d = 1'b1;
      end else if (active_q) begin
        idx_d    = idx_q + 2'd1;
        active_d = (idx_q != 2'd3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    char_q <= char_d;
    eol_q  <= eol_d;
    last_q <= last_d;
  end

endmodule

>>> hw/rtl/base64_line_encoder.sv
`timescale 1ns / 1ps
// top level of the streaming base64 encoder with line breaks
//
//   channel  dir  payload                          beat
//   in_i     in   data_byte[7:0], final_byte       one raw byte
//   out_o    out  out_char[6:0], line_end, run_last one character
//
// a byte is taken every cycle while the group queue has room
// the back end sends four characters per group, one per cycle while not stalled,
// so the sustained rate is set by that unit: four characters for every three bytes
// a closed group is queued, then its first character is registered in the back end
// a stalled output holds its character; the input keeps filling the queue meanwhile
// reset clears phase, line count, queue and output valid; no clearing pass
module base64_line_encoder
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  b64e_in_if.sink    in_i,
  b64e_out_if.source out_o
);

  logic    push;
  logic    pop;
  grp_t    grp_in;
  grp_t    head;
  q_stat_t q_stat;

  b64e_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .grp_o    (grp_in)
  );

  b64e_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .grp_i  (grp_in),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  b64e_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .head_i   (head),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

>>> hw/rtl/b64e_checker.sv
`timescale 1ns / 1ps
// port-level checks for the base64 encoder, bound to the top level
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       line_end_i,
  input logic       run_last_i
);

  logic [1:0] pos_q;
  logic       out_beat;

  assign out_beat = out_valid_i && out_ready_i;

  // position of the next character within its group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else if (out_beat) begin
      pos_q <= run_last_i ? 2'd0 : pos_q + 2'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_char_i) && $stable(line_end_i) && $stable(run_last_i))
    else $error("output beat changed while stalled");

  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && line_end_i |-> run_last_i)
    else $error("line end off a group boundary");

  a_group_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (run_last_i == (pos_q == 2'd3)))
    else $error("group is not four characters");

  a_pad_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && (out_char_i == 7'd61) |-> (pos_q == 2'd2 || pos_q == 2'd3))
    else $error("padding in the first half of a group");

endmodule

bind base64_line_encoder b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .line_end_i  (out_o.line_end),
  .run_last_i  (out_o.run_last)
);
